@@ hdl/assert_macros.svh @@
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define CLL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define CLL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/cll_pkg.sv @@
// types, codes and constants of the code lock with lockout
package cll_pkg;

    localparam int CODE_W     = 14;
    localparam int MASTER_W   = 27;
    localparam int CFG_W      = 27;
    localparam int CFG_IDX_W  = 1;
    localparam int FAIL_W     = 4;

    localparam logic [FAIL_W-1:0] MAX_FAILURES = 4'd3;
    localparam logic [FAIL_W-1:0] FAIL_LIMIT   = 4'd15;
    // fail_count shown by a wrong code that blocks the lock
    localparam logic [1:0] FAIL_AT_BLOCK =
        (MAX_FAILURES > 4'd3) ? 2'd3 : MAX_FAILURES[1:0];

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UNLOCK_CODE  = 1'd1;

    // opcodes
    localparam logic [1:0] OP_OPEN   = 2'd0;
    localparam logic [1:0] OP_CLOSE  = 2'd1;
    localparam logic [1:0] OP_UNLOCK = 2'd2;
    localparam logic [1:0] OP_CHANGE = 2'd3;

    // status codes
    localparam logic [3:0] ST_OPENED         = 4'd0;
    localparam logic [3:0] ST_ALREADY_OPEN   = 4'd1;
    localparam logic [3:0] ST_BLOCKED        = 4'd2;
    localparam logic [3:0] ST_WRONG_CODE     = 4'd3;
    localparam logic [3:0] ST_WRONG_BLOCKED  = 4'd4;
    localparam logic [3:0] ST_CLOSED         = 4'd5;
    localparam logic [3:0] ST_ALREADY_CLOSED = 4'd6;
    localparam logic [3:0] ST_UNLOCKED       = 4'd7;
    localparam logic [3:0] ST_NOT_BLOCKED    = 4'd8;
    localparam logic [3:0] ST_WRONG_MASTER   = 4'd9;
    localparam logic [3:0] ST_NOT_OPEN       = 4'd10;
    localparam logic [3:0] ST_CHANGE_STEP    = 4'd11;
    localparam logic [3:0] ST_CODE_CHANGED   = 4'd12;
    localparam logic [3:0] ST_CHANGE_FAILED  = 4'd13;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [CODE_W-1:0]   code_attempt;
        logic [MASTER_W-1:0] unlock_attempt;
        logic [CODE_W-1:0]   old_code;
        logic [CODE_W-1:0]   new_code;
    } cmd_t;

    typedef struct packed {
        logic [3:0] status;
        logic [1:0] fail_count;
    } res_t;

    typedef struct packed {
        logic              is_open;
        logic              is_blocked;
        logic [FAIL_W-1:0] failures;
        logic [CODE_W-1:0] current_code;
        logic [CODE_W-1:0] pending_code;
        logic              pending_valid;
    } lock_state_t;

endpackage

@@ hdl/cll_eval.sv @@
// decision logic for one command: result and next lock state
module cll_eval (
    input  cll_pkg::cmd_t                   cmd,
    input  cll_pkg::lock_state_t            state,
    input  logic [cll_pkg::MASTER_W-1:0]    unlock_code,
    output cll_pkg::lock_state_t            state_next,
    output cll_pkg::res_t                   res
);

    logic [cll_pkg::FAIL_W-1:0] fail_inc;
    logic [3:0]                 status;

    assign fail_inc = (state.failures < cll_pkg::FAIL_LIMIT) ?
                      state.failures + 1'b1 : state.failures;

    always_comb
    begin
        state_next = state;
        status     = cll_pkg::ST_NOT_OPEN;
        case (cmd.opcode)
            cll_pkg::OP_OPEN:
            begin
                if (state.is_blocked)
                    status = cll_pkg::ST_BLOCKED;
                else if (state.is_open)
                    status = cll_pkg::ST_ALREADY_OPEN;
                else if (cmd.code_attempt == state.current_code)
                begin
                    state_next.is_open  = 1'b1;
                    state_next.failures = '0;
                    status              = cll_pkg::ST_OPENED;
                end
                else
                begin
                    state_next.failures = fail_inc;
                    if (fail_inc >= cll_pkg::MAX_FAILURES)
                    begin
                        state_next.is_blocked = 1'b1;
                        status                = cll_pkg::ST_WRONG_BLOCKED;
                    end
                    else
                        status = cll_pkg::ST_WRONG_CODE;
                end
            end
            cll_pkg::OP_CLOSE:
            begin
                if (state.is_blocked)
                    status = cll_pkg::ST_BLOCKED;
                else if (!state.is_open)
                    status = cll_pkg::ST_ALREADY_CLOSED;
                else
                begin
                    state_next.is_open = 1'b0;
                    status             = cll_pkg::ST_CLOSED;
                end
            end
            cll_pkg::OP_UNLOCK:
            begin
                if (!state.is_blocked)
                    status = cll_pkg::ST_NOT_BLOCKED;
                else if (cmd.unlock_attempt == unlock_code)
                begin
                    state_next.is_blocked = 1'b0;
                    state_next.failures   = '0;
                    status                = cll_pkg::ST_UNLOCKED;
                end
                else
                    status = cll_pkg::ST_WRONG_MASTER;
            end
            cll_pkg::OP_CHANGE:
            begin
                if (!state.is_open)
                    status = cll_pkg::ST_NOT_OPEN;
                else if (!state.pending_valid && cmd.old_code == state.current_code)
                begin
                    state_next.pending_code  = cmd.new_code;
                    state_next.pending_valid = 1'b1;
                    status                   = cll_pkg::ST_CHANGE_STEP;
                end
                else if (state.pending_valid && state.pending_code == cmd.new_code)
                begin
                    state_next.current_code  = cmd.new_code;
                    state_next.pending_valid = 1'b0;
                    status                   = cll_pkg::ST_CODE_CHANGED;
                end
                else
                begin
                    state_next.pending_valid = 1'b0;
                    status                   = cll_pkg::ST_CHANGE_FAILED;
                end
            end
            default:
            begin
                state_next = state;
                status     = cll_pkg::ST_NOT_OPEN;
            end
        endcase
    end

    // count saturates at three in the result
    assign res.status     = status;
    assign res.fail_count = (state_next.failures > 4'd3) ? 2'd3 : state_next.failures[1:0];

endmodule

@@ hdl/cll_state.sv @@
// lock state and configuration registers
module cll_state (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            upd,
    input  cll_pkg::lock_state_t            state_next,
    input  logic                            cfg_we,
    input  logic [cll_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cll_pkg::CFG_W-1:0]       cfg_wdata,
    output cll_pkg::lock_state_t            state,
    output logic [cll_pkg::MASTER_W-1:0]    unlock_code
);

    cll_pkg::lock_state_t              state_reg;
    logic [cll_pkg::MASTER_W-1:0]      unlock_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= '0;
            unlock_code_reg <= '0;
        end
        else
        begin
            if (upd)
                state_reg <= state_next;
            // initial code goes straight into the current code
            if (cfg_we && cfg_index == cll_pkg::REG_INITIAL_CODE)
                state_reg.current_code <= cfg_wdata[cll_pkg::CODE_W-1:0];
            if (cfg_we && cfg_index == cll_pkg::REG_UNLOCK_CODE)
                unlock_code_reg <= cfg_wdata[cll_pkg::MASTER_W-1:0];
        end
    end

    assign state       = state_reg;
    assign unlock_code = unlock_code_reg;

endmodule

@@ hdl/code_lock_with_lockout_core.sv @@
// code lock with lockout: input register, decision logic, result register
// an item waits in cmd_reg; its result enters res_reg when that slot is free or emptying
// throughput: one item per cycle unless a result stalls; state loop closes via cll_eval
// the input stage keeps taking items while a result waits, as long as one slot is free
// reset (rst_n, async, active low): lock closed, not blocked, no failures, no pending
// change, current code and master code zero, both stages empty
module code_lock_with_lockout_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  cll_pkg::cmd_t                   cmd,
    output logic                            out_valid,
    input  logic                            out_ready,
    output cll_pkg::res_t                   result,
    input  logic                            cfg_we,
    input  logic [cll_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cll_pkg::CFG_W-1:0]       cfg_wdata
);

    logic                           in_valid_reg;
    cll_pkg::cmd_t                  cmd_reg;
    logic                           out_valid_reg;
    cll_pkg::res_t                  res_reg;
    logic                           advance;
    cll_pkg::lock_state_t           state;
    cll_pkg::lock_state_t           state_next;
    cll_pkg::res_t                  res_next;
    logic [cll_pkg::MASTER_W-1:0]   unlock_code;

    // the held item moves on when the result slot is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            cmd_reg <= cmd;
        if (advance)
            res_reg <= res_next;
    end

    cll_eval u_eval (
        .cmd         (cmd_reg),
        .state       (state),
        .unlock_code (unlock_code),
        .state_next  (state_next),
        .res         (res_next)
    );

    cll_state u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .upd         (advance),
        .state_next  (state_next),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .state       (state),
        .unlock_code (unlock_code)
    );

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

endmodule

@@ hdl/cll_checker.sv @@
// port-level checks for the code lock core, bound to the top level
`include "assert_macros.svh"

module cll_checker (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            out_valid,
    input  logic            out_ready,
    input  cll_pkg::res_t   result
);

    `CLL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(result), "result dropped or changed while stalled")

    `CLL_ASSERT_NOW(a_open_clears, clk, rst_n, out_valid && result.status == cll_pkg::ST_OPENED, result.fail_count == 2'd0, "opened with nonzero fail count")

    `CLL_ASSERT_NOW(a_unlock_clears, clk, rst_n, out_valid && result.status == cll_pkg::ST_UNLOCKED, result.fail_count == 2'd0, "unlocked with nonzero fail count")

    `CLL_ASSERT_NOW(a_block_count, clk, rst_n, out_valid && result.status == cll_pkg::ST_WRONG_BLOCKED, result.fail_count == cll_pkg::FAIL_AT_BLOCK, "blocked at wrong fail count")

endmodule

bind code_lock_with_lockout_core cll_checker u_cll_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result)
);

@@ tb/lock_result_checker.sv @@
// checker for the code lock: watches both channels and the register port, predicts and compares
module lock_result_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  cll_pkg::cmd_t                   cmd,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  cll_pkg::res_t                   result,
    input  logic                            cfg_we,
    input  logic [cll_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cll_pkg::CFG_W-1:0]       cfg_wdata,
    output int                              mismatch_count,
    output int                              outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    cll_pkg::lock_state_t           lock_st;
    logic [cll_pkg::MASTER_W-1:0]   master_code;
    cll_pkg::res_t                  expected_results[$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // one command against the predicted lock state
    task automatic predict_lock_step(input cll_pkg::cmd_t c, output cll_pkg::res_t r);
        logic [3:0] st;
        st = cll_pkg::ST_NOT_OPEN;
        case (c.opcode)
            cll_pkg::OP_OPEN:
            begin
                if (lock_st.is_blocked)
                    st = cll_pkg::ST_BLOCKED;
                else if (lock_st.is_open)
                    st = cll_pkg::ST_ALREADY_OPEN;
                else if (c.code_attempt == lock_st.current_code)
                begin
                    lock_st.is_open  = 1'b1;
                    lock_st.failures = '0;
                    st = cll_pkg::ST_OPENED;
                end
                else
                begin
                    if (lock_st.failures < cll_pkg::FAIL_LIMIT)
                        lock_st.failures = lock_st.failures + 1'b1;
                    if (lock_st.failures >= cll_pkg::MAX_FAILURES)
                    begin
                        lock_st.is_blocked = 1'b1;
                        st = cll_pkg::ST_WRONG_BLOCKED;
                    end
                    else
                        st = cll_pkg::ST_WRONG_CODE;
                end
            end
            cll_pkg::OP_CLOSE:
            begin
                if (lock_st.is_blocked)
                    st = cll_pkg::ST_BLOCKED;
                else if (!lock_st.is_open)
                    st = cll_pkg::ST_ALREADY_CLOSED;
                else
                begin
                    lock_st.is_open = 1'b0;
                    st = cll_pkg::ST_CLOSED;
                end
            end
            cll_pkg::OP_UNLOCK:
            begin
                if (!lock_st.is_blocked)
                    st = cll_pkg::ST_NOT_BLOCKED;
                else if (c.unlock_attempt == master_code)
                begin
                    lock_st.is_blocked = 1'b0;
                    lock_st.failures   = '0;
                    st = cll_pkg::ST_UNLOCKED;
                end
                else
                    st = cll_pkg::ST_WRONG_MASTER;
            end
            default:
            begin
                if (!lock_st.is_open)
                    st = cll_pkg::ST_NOT_OPEN;
                else if (!lock_st.pending_valid && c.old_code == lock_st.current_code)
                begin
                    lock_st.pending_code  = c.new_code;
                    lock_st.pending_valid = 1'b1;
                    st = cll_pkg::ST_CHANGE_STEP;
                end
                else if (lock_st.pending_valid && lock_st.pending_code == c.new_code)
                begin
                    lock_st.current_code  = c.new_code;
                    lock_st.pending_valid = 1'b0;
                    lock_st.pending_code  = '0;
                    st = cll_pkg::ST_CODE_CHANGED;
                end
                else
                begin
                    lock_st.pending_valid = 1'b0;
                    lock_st.pending_code  = '0;
                    st = cll_pkg::ST_CHANGE_FAILED;
                end
            end
        endcase
        r.status     = st;
        r.fail_count = (lock_st.failures > 4'd3) ? 2'd3 : lock_st.failures[1:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        cll_pkg::res_t want;
        if (!rst_n)
        begin
            lock_st     = '0;
            master_code = '0;
            expected_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    cll_pkg::REG_INITIAL_CODE:
                        lock_st.current_code = cfg_wdata[cll_pkg::CODE_W-1:0];
                    cll_pkg::REG_UNLOCK_CODE:
                        master_code = cfg_wdata[cll_pkg::MASTER_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                predict_lock_step(cmd, want);
                expected_results.insert(expected_results.size(), want);
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result status %0d with no item waiting",
                                              result.status));
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  result.status, want.status));
                    if (result.fail_count !== want.fail_count)
                        report_mismatch($sformatf("fail_count got %0d want %0d",
                                                  result.fail_count, want.fail_count));
                end
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// testbench top for the code lock: clock, reset, stimulus, receiver and verdict
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 750;
    localparam int NUM_PHASES   = 8;
    localparam int CODE_W       = cll_pkg::CODE_W;
    localparam int MASTER_W     = cll_pkg::MASTER_W;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    cll_pkg::cmd_t                  cmd;
    logic                           out_valid;
    logic                           out_ready;
    cll_pkg::res_t                  result;
    logic                           cfg_we;
    logic [cll_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [cll_pkg::CFG_W-1:0]      cfg_wdata;

    int mismatch_count;
    int outstanding;
    int cycle_cnt;
    int items_sent;
    int idle_pct;
    int stall_pct;
    int hold_reqs;
    int holds_done;

    logic [CODE_W-1:0]   known_code;
    logic [MASTER_W-1:0] known_master;

    code_lock_with_lockout_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lock_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result         (result),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off when asked for
    initial
    begin
        holds_done = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_reqs != holds_done)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                holds_done++;
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [CODE_W-1:0] rand_code();
        if ($urandom_range(99) < 70)
            return CODE_W'($urandom_range(9999));
        return CODE_W'($urandom);
    endfunction

    function automatic logic [MASTER_W-1:0] rand_master();
        if ($urandom_range(99) < 70)
            return MASTER_W'($urandom_range(99999999));
        return MASTER_W'($urandom);
    endfunction

    function automatic logic [CODE_W-1:0] nonzero_code();
        return CODE_W'($urandom_range((1 << CODE_W) - 1, 1));
    endfunction

    function automatic logic [MASTER_W-1:0] nonzero_master();
        return MASTER_W'($urandom_range((1 << MASTER_W) - 1, 1));
    endfunction

    // unused fields carry random content
    function automatic cll_pkg::cmd_t lock_cmd(input logic [1:0] op);
        cll_pkg::cmd_t c;
        c.opcode         = op;
        c.code_attempt   = rand_code();
        c.unlock_attempt = rand_master();
        c.old_code       = rand_code();
        c.new_code       = rand_code();
        return c;
    endfunction

    // called at a rising edge; returns at the edge where the item is accepted
    task automatic send_cmd(input cll_pkg::cmd_t c);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic send_open(input logic [CODE_W-1:0] code);
        cll_pkg::cmd_t c;
        c = lock_cmd(cll_pkg::OP_OPEN);
        c.code_attempt = code;
        send_cmd(c);
    endtask

    task automatic send_close();
        send_cmd(lock_cmd(cll_pkg::OP_CLOSE));
    endtask

    task automatic send_unlock(input logic [MASTER_W-1:0] master);
        cll_pkg::cmd_t c;
        c = lock_cmd(cll_pkg::OP_UNLOCK);
        c.unlock_attempt = master;
        send_cmd(c);
    endtask

    task automatic send_change(input logic [CODE_W-1:0] old_c, input logic [CODE_W-1:0] new_c);
        cll_pkg::cmd_t c;
        c = lock_cmd(cll_pkg::OP_CHANGE);
        c.old_code = old_c;
        c.new_code = new_c;
        send_cmd(c);
    endtask

    // sender pause until every item has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_regs(input logic [CODE_W-1:0] code, input logic [MASTER_W-1:0] master);
        cfg_we    <= 1'b1;
        cfg_index <= cll_pkg::REG_INITIAL_CODE;
        cfg_wdata <= {13'($urandom), code};
        @(posedge clk);
        cfg_index <= cll_pkg::REG_UNLOCK_CODE;
        cfg_wdata <= master;
        @(posedge clk);
        cfg_we <= 1'b0;
        known_code   = code;
        known_master = master;
    endtask

    // a plausible user session: maybe lock out, unlock, open, change code, close
    task automatic run_session();
        logic [CODE_W-1:0] fresh;
        int n;
        if ($urandom_range(99) < 25)
        begin
            n = $urandom_range(3, 1);
            repeat (n) send_open(known_code ^ nonzero_code());
            if ($urandom_range(1))
                send_close();
        end
        if ($urandom_range(99) < 15)
            send_unlock(known_master ^ nonzero_master());
        send_unlock(known_master);
        if ($urandom_range(99) < 15)
            send_change(rand_code(), rand_code());
        if ($urandom_range(99) < 10)
            send_open(known_code ^ nonzero_code());
        send_open(known_code);
        if ($urandom_range(99) < 20)
            send_open(rand_code());
        if ($urandom_range(99) < 60)
        begin
            fresh = rand_code();
            // clears any pending change left behind
            send_change(known_code ^ nonzero_code(), rand_code());
            send_change(known_code, fresh);
            if ($urandom_range(99) < 30)
                send_open(rand_code());
            if ($urandom_range(99) < 85)
            begin
                send_change(known_code ^ nonzero_code(), fresh);
                known_code = fresh;
            end
            else
                send_change(known_code ^ nonzero_code(), fresh ^ nonzero_code());
        end
        if ($urandom_range(99) < 70)
            send_close();
        if ($urandom_range(99) < 20)
            send_close();
    endtask

    initial
    begin : stimulus
        int phase;
        int target;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        cmd        <= '0;
        cfg_we     <= 1'b0;
        cfg_index  <= '0;
        cfg_wdata  <= '0;
        stall_pct  <= 0;
        hold_reqs  <= 0;
        idle_pct     = 0;
        items_sent   = 0;
        known_code   = '0;
        known_master = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset codes are zero
        send_close();
        send_unlock(nonzero_master());
        send_change('0, '0);
        send_open('1);
        send_open(CODE_W'(9999));
        send_open(CODE_W'(1));
        send_open('0);                 // right code while blocked
        send_close();                  // close while blocked
        send_change('0, '0);
        send_unlock('1);
        send_unlock(MASTER_W'(99999999));
        send_unlock('0);
        send_open('0);
        send_open('0);
        send_change(CODE_W'(1), CODE_W'(5));
        send_change('0, '1);
        send_change(CODE_W'(3), CODE_W'(16382));
        send_change('0, '1);
        send_open(CODE_W'(5));         // other commands keep the pending code
        send_unlock('0);
        send_change(CODE_W'(7), '1);
        send_close();
        send_open('1);
        send_change('1, CODE_W'(9999));
        send_close();
        send_change(rand_code(), rand_code());   // change while closed keeps pending
        send_open('1);
        send_change('0, CODE_W'(9999));
        known_code = CODE_W'(9999);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: write_regs(CODE_W'(9999), MASTER_W'(99999999));
                1: write_regs('1, '1);
                2: write_regs('0, '0);
                default: write_regs(rand_code(), rand_master());
            endcase
            case (phase % 4)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 53; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 53; end
                default: begin idle_pct = 30; stall_pct <= 30; end
            endcase
            // long receiver hold-off while the sender keeps pushing
            if (phase == 4)
                hold_reqs <= hold_reqs + 1;
            target = items_sent + RANDOM_ITEMS / NUM_PHASES;
            while (items_sent < target)
            begin
                if ($urandom_range(99) < 75)
                    run_session();
                else
                    send_cmd(lock_cmd(2'($urandom)));
            end
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
